@@ sv/drmt_pkg.sv @@
// Shared types and constants for the dirty region merge table.
// Used by drmt_ram and dirty_region_merge_table_top; no dependencies.
package drmt_pkg;

	localparam int DEFAULT_MAX_ENTRIES = 16;

	typedef enum logic [1:0] {
		KIND_MARK  = 2'd0,
		KIND_SHIFT = 2'd1,
		KIND_DRAIN = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [15:0] row;
		logic        whole_row;
		logic [7:0]  piece;
		logic        whole_piece;
		logic [9:0]  col_start;
		logic [9:0]  col_end;
	} region_t;

	typedef struct packed {
		logic        entry_valid;
		logic        full_repaint;
		logic [15:0] row;
		logic        whole_row;
		logic [7:0]  piece;
		logic        whole_piece;
		logic [9:0]  col_start;
		logic [9:0]  col_end;
		logic        last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_READ,
		ST_EVAL,
		ST_END,
		ST_PROMO,
		ST_STATUS
	} state_t;

endpackage

@@ sv/drmt_ram.sv @@
// Region table storage: one write port, one read port with registered data.
// Depends on drmt_pkg for region_t.
module drmt_ram #(
	parameter int DEPTH = drmt_pkg::DEFAULT_MAX_ENTRIES,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  drmt_pkg::region_t wdata,
	input  logic [AW-1:0]     raddr,
	output drmt_pkg::region_t rdata
);

	drmt_pkg::region_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ sv/dirty_region_merge_table_top.sv @@
// Dirty region merge table: top level with the entry-walk sequencer.
// Depends on drmt_pkg and drmt_ram.
//
// Usage: items arrive on the in_* channel (valid/ready). A mark merges into
// or appends to the region table, a shift adds a signed amount to every
// stored row, a drain reports the full-repaint flag or every visible region
// and then empties the table. Results leave on the out_* channel through one
// output register; 'last' flags the final beat of an item. visible_rows is
// written over the cfg_* channel, which is always ready.
// Sequencing: the sequencer walks the table through the single RAM read port,
// reading each stored entry and then evaluating it. in_ready is high only
// while the sequencer is idle, so one item is in work at a time.
// When the receiver stalls, the sequencer waits at the next beat it must
// issue; a finished beat may sit in the output register while a new item is
// accepted. Reset empties the table, clears the repaint flag and sets
// visible_rows to zero; RAM contents need no clearing.
module dirty_region_merge_table_top #(
	parameter int MAX_ENTRIES = drmt_pkg::DEFAULT_MAX_ENTRIES,
	parameter int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [14:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic signed [15:0] row,
	input  logic               whole_row,
	input  logic [7:0]         piece,
	input  logic               whole_piece,
	input  logic [9:0]         col_start,
	input  logic [9:0]         col_end,
	input  logic signed [15:0] shift,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               entry_valid,
	output logic               full_repaint,
	output logic signed [15:0] out_row,
	output logic               out_whole_row,
	output logic [7:0]         out_piece,
	output logic               out_whole_piece,
	output logic [9:0]         out_col_start,
	output logic [9:0]         out_col_end,
	output logic [CW-1:0]      entry_count,
	output logic               last
);

	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

	drmt_pkg::state_t  state_q, state_d;
	logic [14:0]       vis_q;
	logic [CW-1:0]     used_q;
	logic              rep_q;
	logic [CW-1:0]     idx_q;
	logic [AW-1:0]     same_idx_q;
	logic              same_v_q;
	drmt_pkg::region_t pend_q;
	logic              pend_v_q;

	// captured input item
	drmt_pkg::kind_t   kind_q;
	drmt_pkg::region_t mark_q;
	logic [15:0]       shift_q;

	drmt_pkg::result_t out_q;
	logic [CW-1:0]     cnt_q;
	logic              out_valid_q;

	// RAM port
	logic              we;
	logic [AW-1:0]     waddr, raddr;
	drmt_pkg::region_t wdata, rd;

	// sequencer controls
	logic              out_ld;
	drmt_pkg::result_t out_d;
	logic              idx_inc, tab_clr, rep_set, used_inc, pend_ld, same_ld;

	logic out_free, hit_row, hit_piece, vis, walk_done, tab_full;

	function automatic drmt_pkg::result_t entry_res(drmt_pkg::region_t e, logic lst);
		drmt_pkg::result_t r;
		r = '0;
		r.entry_valid = 1'b1;
		r.row         = e.row;
		r.last        = lst;
		if (e.whole_row) begin
			r.whole_row = 1'b1;
		end else begin
			r.piece = e.piece;
			if (e.whole_piece) begin
				r.whole_piece = 1'b1;
			end else begin
				r.col_start = e.col_start;
				r.col_end   = e.col_end;
			end
		end
		return r;
	endfunction

	drmt_ram #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign hit_row   = (rd.row == mark_q.row);
	assign hit_piece = (rd.piece == mark_q.piece);
	assign vis       = !rd.row[15] && (rd.row[14:0] < vis_q);
	assign walk_done = (idx_q == used_q);
	assign tab_full  = (used_q >= MAX_CNT);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == drmt_pkg::ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			drmt_pkg::ST_IDLE: begin
				if (in_valid) state_d = drmt_pkg::ST_START;
			end
			drmt_pkg::ST_START: begin
				if (kind_q == drmt_pkg::KIND_DRAIN && rep_q) begin
					if (out_free) state_d = drmt_pkg::ST_IDLE;
				end else if (kind_q == drmt_pkg::KIND_NOP) begin
					state_d = drmt_pkg::ST_STATUS;
				end else begin
					state_d = drmt_pkg::ST_READ;
				end
			end
			drmt_pkg::ST_READ: begin
				state_d = walk_done ? drmt_pkg::ST_END : drmt_pkg::ST_EVAL;
			end
			drmt_pkg::ST_EVAL: begin
				case (kind_q)
					drmt_pkg::KIND_MARK: begin
						if (hit_row && (rd.whole_row || mark_q.whole_row || hit_piece))
							state_d = drmt_pkg::ST_STATUS;
						else
							state_d = drmt_pkg::ST_READ;
					end
					drmt_pkg::KIND_DRAIN: begin
						if (!(vis && pend_v_q && !out_free)) state_d = drmt_pkg::ST_READ;
					end
					default: state_d = drmt_pkg::ST_READ;
				endcase
			end
			drmt_pkg::ST_END: begin
				case (kind_q)
					drmt_pkg::KIND_MARK: begin
						state_d = (tab_full && same_v_q) ? drmt_pkg::ST_PROMO
							: drmt_pkg::ST_STATUS;
					end
					drmt_pkg::KIND_DRAIN: begin
						if (out_free) state_d = drmt_pkg::ST_IDLE;
					end
					default: state_d = drmt_pkg::ST_STATUS;
				endcase
			end
			drmt_pkg::ST_PROMO:  state_d = drmt_pkg::ST_STATUS;
			drmt_pkg::ST_STATUS: begin
				if (out_free) state_d = drmt_pkg::ST_IDLE;
			end
			default: state_d = drmt_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		raddr    = idx_q[AW-1:0];
		we       = 1'b0;
		waddr    = idx_q[AW-1:0];
		wdata    = rd;
		out_ld   = 1'b0;
		out_d    = '0;
		idx_inc  = 1'b0;
		tab_clr  = 1'b0;
		rep_set  = 1'b0;
		used_inc = 1'b0;
		pend_ld  = 1'b0;
		same_ld  = 1'b0;
		case (state_q)
			drmt_pkg::ST_START: begin
				if (kind_q == drmt_pkg::KIND_DRAIN && rep_q && out_free) begin
					out_ld             = 1'b1;
					out_d.full_repaint = 1'b1;
					out_d.last         = 1'b1;
					tab_clr            = 1'b1;
				end
			end
			drmt_pkg::ST_EVAL: begin
				case (kind_q)
					drmt_pkg::KIND_MARK: begin
						idx_inc = 1'b1;
						if (hit_row) begin
							same_ld = 1'b1;
							if (rd.whole_row || mark_q.whole_row) begin
								we              = 1'b1;
								wdata.whole_row = 1'b1;
							end else if (hit_piece) begin
								we = 1'b1;
								if (rd.whole_piece || mark_q.whole_piece) begin
									wdata.whole_piece = 1'b1;
								end else begin
									if (rd.col_start > mark_q.col_start)
										wdata.col_start = mark_q.col_start;
									if (rd.col_end < mark_q.col_end)
										wdata.col_end = mark_q.col_end;
								end
							end
						end
					end
					drmt_pkg::KIND_SHIFT: begin
						idx_inc   = 1'b1;
						we        = 1'b1;
						wdata.row = rd.row + shift_q;
					end
					drmt_pkg::KIND_DRAIN: begin
						if (!vis) begin
							idx_inc = 1'b1;
						end else if (!pend_v_q || out_free) begin
							idx_inc = 1'b1;
							pend_ld = 1'b1;
							if (pend_v_q) begin
								out_ld = 1'b1;
								out_d  = entry_res(pend_q, 1'b0);
							end
						end
					end
					default: ;
				endcase
			end
			drmt_pkg::ST_END: begin
				raddr = same_idx_q;
				case (kind_q)
					drmt_pkg::KIND_MARK: begin
						if (tab_full) begin
							if (!same_v_q) rep_set = 1'b1;
						end else begin
							we       = 1'b1;
							waddr    = used_q[AW-1:0];
							wdata    = mark_q;
							used_inc = 1'b1;
							if (mark_q.whole_row) begin
								wdata.piece       = '0;
								wdata.whole_piece = 1'b0;
							end
							if (mark_q.whole_row || mark_q.whole_piece) begin
								wdata.col_start = '0;
								wdata.col_end   = '0;
							end
						end
					end
					drmt_pkg::KIND_DRAIN: begin
						if (out_free) begin
							out_ld  = 1'b1;
							tab_clr = 1'b1;
							if (pend_v_q) out_d = entry_res(pend_q, 1'b1);
							else out_d.last = 1'b1;
						end
					end
					default: ;
				endcase
			end
			drmt_pkg::ST_PROMO: begin
				raddr           = same_idx_q;
				we              = 1'b1;
				waddr           = same_idx_q;
				wdata.whole_row = 1'b1;
			end
			drmt_pkg::ST_STATUS: begin
				if (out_free) begin
					out_ld             = 1'b1;
					out_d.full_repaint = rep_q;
					out_d.last         = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= drmt_pkg::ST_IDLE;
			vis_q       <= '0;
			used_q      <= '0;
			rep_q       <= 1'b0;
			idx_q       <= '0;
			same_v_q    <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) vis_q <= cfg_data;
			if (state_q == drmt_pkg::ST_START) begin
				idx_q    <= '0;
				same_v_q <= 1'b0;
				pend_v_q <= 1'b0;
			end else if (idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (same_ld) same_v_q <= 1'b1;
			if (pend_ld) pend_v_q <= 1'b1;
			if (rep_set) rep_q <= 1'b1;
			if (used_inc) used_q <= used_q + CW'(1);
			if (tab_clr) begin
				used_q <= '0;
				rep_q  <= 1'b0;
			end
			if (out_ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q             <= drmt_pkg::kind_t'(kind);
			mark_q.row         <= row;
			mark_q.whole_row   <= whole_row;
			mark_q.piece       <= piece;
			mark_q.whole_piece <= whole_piece;
			mark_q.col_start   <= col_start;
			mark_q.col_end     <= col_end;
			shift_q            <= shift;
		end
		if (same_ld) same_idx_q <= idx_q[AW-1:0];
		if (pend_ld) pend_q <= rd;
		if (out_ld) begin
			out_q <= out_d;
			// drain beats report an empty table; status beats the live count
			if (kind_q == drmt_pkg::KIND_DRAIN) cnt_q <= '0;
			else cnt_q <= used_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign entry_valid     = out_q.entry_valid;
	assign full_repaint    = out_q.full_repaint;
	assign out_row         = out_q.row;
	assign out_whole_row   = out_q.whole_row;
	assign out_piece       = out_q.piece;
	assign out_whole_piece = out_q.whole_piece;
	assign out_col_start   = out_q.col_start;
	assign out_col_end     = out_q.col_end;
	assign entry_count     = cnt_q;
	assign last            = out_q.last;

endmodule

@@ test/testbench.sv @@
// Testbench for dirty_region_merge_table_top: directed and random marks, shifts
// and drains against a predicting checker, with random stalls on both channels.
// Depends on drmt_pkg and the dirty_region_merge_table_top RTL.
module testbench;

	localparam int MAX_REGIONS   = drmt_pkg::DEFAULT_MAX_ENTRIES;
	localparam int STALL_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 32;
	localparam int SETTLE_CYCLES = 40;
	localparam int REPORT_LIMIT  = 10;

	typedef enum int {SEQ_MERGE, SEQ_FILL, SEQ_SHIFT, SEQ_NOISE} seq_kind_t;

	typedef struct {
		drmt_pkg::kind_t kind;
		logic [15:0]     row;
		logic            whole_row;
		logic [7:0]      piece;
		logic            whole_piece;
		logic [9:0]      col_start;
		logic [9:0]      col_end;
		logic [15:0]     shift;
	} item_t;

	typedef struct packed {
		logic        entry_valid;
		logic        full_repaint;
		logic [15:0] row;
		logic        whole_row;
		logic [7:0]  piece;
		logic        whole_piece;
		logic [9:0]  col_start;
		logic [9:0]  col_end;
		logic [4:0]  entry_count;
		logic        last;
	} beat_t;

	class region_table_tracker;
		drmt_pkg::region_t regions[MAX_REGIONS];
		int unsigned used;
		bit          repaint;
		logic [14:0] visible;
		beat_t       pending_beats[$];
		int unsigned mismatches;
		int unsigned beats_seen;
		int unsigned drained_entries;
		int unsigned repaint_drains;
		int unsigned overflows;

		function new();
			visible = '0;
		endfunction

		function void set_visible(logic [14:0] v);
			visible = v;
		endfunction

		function string show(beat_t b);
			return $sformatf("ev=%0b fr=%0b row=%0d wr=%0b pc=%0d wp=%0b cs=%0d ce=%0d cnt=%0d last=%0b",
				b.entry_valid, b.full_repaint, $signed(b.row), b.whole_row, b.piece,
				b.whole_piece, b.col_start, b.col_end, b.entry_count, b.last);
		endfunction

		// Called on every accepted item; queues the beats it must produce.
		function void apply_item(item_t it);
			int    match_idx;
			bit    merged;
			beat_t b;
			b = '0;
			case (it.kind)
				drmt_pkg::KIND_MARK: begin
					match_idx = -1;
					merged = 0;
					for (int i = 0; i < used && !merged; i++) begin
						if (regions[i].row == it.row) begin
							match_idx = i;
							if (regions[i].whole_row || it.whole_row) begin
								regions[i].whole_row = 1'b1;
								merged = 1;
							end else if (regions[i].piece == it.piece) begin
								if (regions[i].whole_piece || it.whole_piece)
									regions[i].whole_piece = 1'b1;
								else begin
									if (regions[i].col_start > it.col_start)
										regions[i].col_start = it.col_start;
									if (regions[i].col_end < it.col_end)
										regions[i].col_end = it.col_end;
								end
								merged = 1;
							end
						end
					end
					if (!merged) begin
						if (used == MAX_REGIONS) begin
							// full: promote the last entry of this row, else give up
							overflows++;
							if (match_idx >= 0)
								regions[match_idx].whole_row = 1'b1;
							else
								repaint = 1'b1;
						end else begin
							regions[used] = '0;
							regions[used].row = it.row;
							regions[used].whole_row = it.whole_row;
							if (!it.whole_row) begin
								regions[used].piece = it.piece;
								regions[used].whole_piece = it.whole_piece;
								if (!it.whole_piece) begin
									regions[used].col_start = it.col_start;
									regions[used].col_end = it.col_end;
								end
							end
							used++;
						end
					end
				end
				drmt_pkg::KIND_SHIFT: begin
					for (int i = 0; i < used; i++)
						regions[i].row = regions[i].row + it.shift;
				end
				drmt_pkg::KIND_DRAIN: begin
					if (repaint) begin
						b.full_repaint = 1'b1;
						repaint_drains++;
					end else begin
						// hold one beat back so the final one can carry last
						for (int i = 0; i < used; i++) begin
							if (!regions[i].row[15] && regions[i].row < {1'b0, visible}) begin
								if (b.entry_valid)
									pending_beats.push_back(b);
								b = '0;
								b.entry_valid = 1'b1;
								b.row = regions[i].row;
								if (regions[i].whole_row)
									b.whole_row = 1'b1;
								else begin
									b.piece = regions[i].piece;
									if (regions[i].whole_piece)
										b.whole_piece = 1'b1;
									else begin
										b.col_start = regions[i].col_start;
										b.col_end = regions[i].col_end;
									end
								end
								drained_entries++;
							end
						end
					end
					b.last = 1'b1;
					pending_beats.push_back(b);
					used = 0;
					repaint = 1'b0;
				end
				default: ;
			endcase
			if (it.kind != drmt_pkg::KIND_DRAIN) begin
				b.full_repaint = repaint;
				b.entry_count = 5'(used);
				b.last = 1'b1;
				pending_beats.push_back(b);
			end
		endfunction

		function void check_beat(beat_t got);
			beat_t want;
			string diffs;
			beats_seen++;
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected beat: %s", show(got));
			end else begin
				want = pending_beats.pop_front();
				diffs = "";
				if (got.entry_valid !== want.entry_valid) diffs = {diffs, " entry_valid"};
				if (got.full_repaint !== want.full_repaint) diffs = {diffs, " full_repaint"};
				if (got.row !== want.row) diffs = {diffs, " out_row"};
				if (got.whole_row !== want.whole_row) diffs = {diffs, " out_whole_row"};
				if (got.piece !== want.piece) diffs = {diffs, " out_piece"};
				if (got.whole_piece !== want.whole_piece) diffs = {diffs, " out_whole_piece"};
				if (got.col_start !== want.col_start) diffs = {diffs, " out_col_start"};
				if (got.col_end !== want.col_end) diffs = {diffs, " out_col_end"};
				if (got.entry_count !== want.entry_count) diffs = {diffs, " entry_count"};
				if (got.last !== want.last) diffs = {diffs, " last"};
				if (diffs != "") begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("beat %0d differs in%s", beats_seen, diffs);
						$display("  expected %s", show(want));
						$display("  actual   %s", show(got));
					end
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [14:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         kind;
	logic signed [15:0] row;
	logic               whole_row;
	logic [7:0]         piece;
	logic               whole_piece;
	logic [9:0]         col_start;
	logic [9:0]         col_end;
	logic signed [15:0] shift;
	logic               out_valid;
	logic               out_ready;
	logic               entry_valid;
	logic               full_repaint;
	logic signed [15:0] out_row;
	logic               out_whole_row;
	logic [7:0]         out_piece;
	logic               out_whole_piece;
	logic [9:0]         out_col_start;
	logic [9:0]         out_col_end;
	logic [4:0]         entry_count;
	logic               last;

	region_table_tracker tracker;
	beat_t       seen;
	int          items_sent = 0;
	int          cfg_writes = 0;
	int          quiet;
	bit          sender_idle = 1'b1;
	bit          receiver_idle = 1'b1;
	bit          hold_pending = 1'b0;
	logic [15:0] row_base = '0;
	int unsigned vis_now = 0;

	dirty_region_merge_table_top dut (.*);

	assign seen = {entry_valid, full_repaint, out_row, out_whole_row, out_piece,
		out_whole_piece, out_col_start, out_col_end, entry_count, last};

	always #10 clk = ~clk;

	function automatic item_t junk_item();
		item_t it;
		it.kind = drmt_pkg::kind_t'($urandom_range(0, 3));
		it.row = 16'($urandom);
		it.whole_row = 1'($urandom);
		it.piece = 8'($urandom);
		it.whole_piece = 1'($urandom);
		it.col_start = 10'($urandom);
		it.col_end = 10'($urandom);
		it.shift = 16'($urandom);
		return it;
	endfunction

	// unused fields stay random; the block must ignore them
	function automatic item_t op_item(drmt_pkg::kind_t k);
		item_t it;
		it = junk_item();
		it.kind = k;
		return it;
	endfunction

	function automatic item_t shift_item(logic [15:0] amount);
		item_t it;
		it = op_item(drmt_pkg::KIND_SHIFT);
		it.shift = amount;
		return it;
	endfunction

	function automatic item_t mark_item(logic [15:0] r, logic [7:0] p, logic [9:0] cs,
			logic [9:0] ce, bit wr, bit wp);
		item_t it;
		it = op_item(drmt_pkg::KIND_MARK);
		it.row = r;
		it.piece = p;
		it.col_start = cs;
		it.col_end = ce;
		it.whole_row = wr;
		it.whole_piece = wp;
		return it;
	endfunction

	// rows cluster near row_base so marks merge; some land on the visibility edges
	function automatic item_t random_mark();
		logic [15:0] r;
		logic [7:0]  p;
		case ($urandom_range(0, 9))
			0: r = 16'($urandom);
			1: r = 16'(vis_now) - 16'($urandom_range(0, 2));
			2: r = -16'($urandom_range(1, 3));
			default: r = row_base + 16'($urandom_range(0, 5));
		endcase
		p = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		return mark_item(r, p, 10'($urandom), 10'($urandom), $urandom_range(0, 9) == 0,
			$urandom_range(0, 7) == 0);
	endfunction

	function automatic seq_kind_t pick_mode();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 8) return SEQ_MERGE;
		if (roll < 11) return SEQ_FILL;
		if (roll < 16) return SEQ_SHIFT;
		return SEQ_NOISE;
	endfunction

	// Leaves in_valid high on return so a back-to-back item keeps it up.
	task automatic send(item_t it);
		int gap;
		gap = sender_idle ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind = it.kind;
		row = it.row;
		whole_row = it.whole_row;
		piece = it.piece;
		whole_piece = it.whole_piece;
		col_start = it.col_start;
		col_end = it.col_end;
		shift = it.shift;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		tracker.apply_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (tracker.pending_beats.size() != 0 || !in_ready)
			@(negedge clk);
	endtask

	task automatic write_visible(logic [14:0] v);
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_visible(v);
		vis_now = v;
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_sequence(seq_kind_t mode);
		int n;
		row_base = 16'($urandom_range(0, 6));
		case (mode)
			SEQ_MERGE: begin
				n = $urandom_range(3, 12);
				for (int i = 0; i < n; i++) begin
					send(random_mark());
					if (i == n / 2 && $urandom_range(0, 3) == 0)
						send(shift_item(16'($urandom_range(0, 6)) - 16'd3));
				end
				if ($urandom_range(0, 7) != 0)
					send(op_item(drmt_pkg::KIND_DRAIN));
			end
			SEQ_FILL: begin
				// distinct rows fill the table, then overflow: first a row that
				// is present (promote), last always a new row (full repaint)
				n = $urandom_range(MAX_REGIONS + 2, MAX_REGIONS + 6);
				for (int i = 0; i < n; i++) begin
					if (i < MAX_REGIONS)
						send(mark_item(row_base + 16'(i), 8'($urandom_range(0, 3)),
							10'($urandom), 10'($urandom), 0, 0));
					else if (i == MAX_REGIONS || (i != n - 1 && $urandom_range(0, 1)))
						send(mark_item(row_base + 16'($urandom_range(0, MAX_REGIONS - 1)),
							8'($urandom_range(4, 255)), 10'($urandom), 10'($urandom), 0, 0));
					else
						send(mark_item(row_base + 16'(100 + i), 8'($urandom),
							10'($urandom), 10'($urandom), 0, 0));
				end
				send(op_item(drmt_pkg::KIND_DRAIN));
			end
			SEQ_SHIFT: begin
				n = $urandom_range(3, 8);
				for (int i = 0; i < n; i++)
					send(random_mark());
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					send(shift_item($urandom_range(0, 1) ? 16'($urandom)
						: 16'($urandom_range(0, 6)) - 16'd3));
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++)
					send(random_mark());
				send(op_item(drmt_pkg::KIND_DRAIN));
			end
			default: begin
				n = $urandom_range(2, 8);
				for (int i = 0; i < n; i++)
					send(junk_item());
			end
		endcase
	endtask

	// receiver: per-beat stall, plus one long hold-off on request
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = receiver_idle ? $urandom_range(0, 7) : 0;
			if (hold_pending) begin
				stall = HOLD_CYCLES;
				hold_pending = 1'b0;
			end
			out_ready = (stall == 0);
			if (stall > 0) begin
				repeat (stall) @(negedge clk);
				out_ready = 1'b1;
			end
			do @(posedge clk); while (!out_valid);
			tracker.check_beat(seen);
			@(negedge clk);
		end
	end

	initial begin
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no handshake for %0d cycles, %0d beats still due",
			STALL_LIMIT, tracker.pending_beats.size());
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int vis_plan[6];
		int phase_start;
		vis_plan = '{20, 0, 9, 32767, 0, 1};
		vis_plan[4] = $urandom_range(2, 32766);
		tracker = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = drmt_pkg::KIND_MARK;
		row = '0;
		whole_row = 1'b0;
		piece = '0;
		whole_piece = 1'b0;
		col_start = '0;
		col_end = '0;
		shift = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		wait_idle();
		write_visible(15'h7FFF);
		send(op_item(drmt_pkg::KIND_DRAIN));
		send(mark_item(16'd0, 8'd0, 10'd5, 10'd10, 0, 0));
		send(mark_item(16'd0, 8'd0, 10'd2, 10'd7, 0, 0));
		send(mark_item(16'd0, 8'd0, 10'd900, 10'd3, 0, 0));
		send(mark_item(16'd0, 8'd1, 10'h3FF, 10'h3FF, 0, 1));
		send(mark_item(16'd0, 8'd1, 10'd4, 10'd6, 0, 0));
		send(mark_item(16'd0, 8'd2, 10'd0, 10'd0, 1, 0));
		send(mark_item(16'd1, 8'hFF, 10'h3FF, 10'h3FF, 1, 1));
		send(mark_item(16'h8000, 8'hFF, 10'h3FF, 10'd0, 0, 0));
		send(mark_item(16'h7FFF, 8'h80, 10'd0, 10'h3FF, 0, 0));
		send(shift_item(16'd1));
		send(op_item(drmt_pkg::KIND_NOP));
		send(shift_item(16'hFFFF));
		// row 32767 sits just outside visible_rows = 32767
		send(op_item(drmt_pkg::KIND_DRAIN));
		send(shift_item(16'h8000));

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			write_visible(15'(vis_plan[p]));
			sender_idle = (p != 3) && (p != 5);
			receiver_idle = (p != 3) && (p != 4);
			if (p == 2)
				hold_pending = 1'b1;
			phase_start = items_sent;
			run_sequence(p == 0 ? SEQ_FILL : pick_mode());
			while (items_sent - phase_start < PHASE_ITEMS)
				run_sequence(pick_mode());
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("covered %0d items and %0d result beats over %0d visible_rows settings",
			items_sent, tracker.beats_seen, cfg_writes);
		$display("drained %0d entries, %0d full repaints, %0d overflows; %0d mismatches",
			tracker.drained_entries, tracker.repaint_drains, tracker.overflows,
			tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending_beats.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
